// ===== rtl/gnss_binary_frame_parser_top_macros.svh =====
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser_top_macros.svh
// Assertion macros for the binary frame parser; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef GNSS_BINARY_FRAME_PARSER_TOP_MACROS_SVH
`define GNSS_BINARY_FRAME_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define GFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define GFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define GFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/gfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gfp_pkg
// Types, codes and helpers for the binary GNSS frame parser.
// ----------------------------------------------------------------------------
package gfp_pkg;

    // Sync pair that opens every frame
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // Register map (index = byte address / 4)
    localparam int unsigned REG_MAX_PAYLOAD_LENGTH = 0;
    localparam logic [15:0] MAX_PAYLOAD_LENGTH_RESET = 16'd1024;

    // Parser phase
    typedef enum logic [3:0] {
        PH_SYNC1    = 4'd0,
        PH_SYNC2    = 4'd1,
        PH_CLASS    = 4'd2,
        PH_ID       = 4'd3,
        PH_LEN_LO   = 4'd4,
        PH_LEN_HI   = 4'd5,
        PH_PAYLOAD  = 4'd6,
        PH_CHECK_A  = 4'd7,
        PH_CHECK_B  = 4'd8
    } phase_t;

    // Message kind codes
    typedef enum logic [2:0] {
        KIND_OTHER   = 3'd0,
        KIND_ACK     = 3'd1,
        KIND_NACK    = 3'd2,
        KIND_VERSION = 3'd3,
        KIND_NAV_ST  = 3'd4,
        KIND_UTC     = 3'd5
    } kind_t;

    // Class / id pairs
    localparam logic [15:0] TYPE_ACK     = 16'h0501;
    localparam logic [15:0] TYPE_NACK    = 16'h0500;
    localparam logic [15:0] TYPE_VERSION = 16'h0A04;
    localparam logic [15:0] TYPE_NAV_ST  = 16'h0103;
    localparam logic [15:0] TYPE_UTC     = 16'h0121;

    // Map class and id to a message kind
    function automatic kind_t decode_kind(input logic [15:0] frame_type);
        kind_t k;
        k = KIND_OTHER;
        unique case (frame_type)
            TYPE_ACK:     k = KIND_ACK;
            TYPE_NACK:    k = KIND_NACK;
            TYPE_VERSION: k = KIND_VERSION;
            TYPE_NAV_ST:  k = KIND_NAV_ST;
            TYPE_UTC:     k = KIND_UTC;
            default:      k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/gnss_binary_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser_top
// Byte-wide frame parser: sync hunt, header, payload capture, Fletcher check
// and decode of ack/nack/version/nav status/UTC time frames.
// ----------------------------------------------------------------------------
//  Channel   Signals                              Beat
//  -------   ----------------------------------   ---------------------------
//  input     in_valid / in_ready / rx_byte        one received byte
//  output    out_valid / out_ready / 12 fields    one decoded frame
//  config    APB psel/penable/pwrite/paddr/...    max_payload_length @ 0x0
//
//  One byte per cycle; each byte updates the phase, sums and capture in the
//  cycle it is accepted. The result is registered on the second check byte
//  and shows in the next cycle. Only a second check byte waits while a result
//  is still held; every other byte passes freely. Reset (async, rst_n low)
//  returns to the sync hunt and sets max_payload_length to 1024.
// ----------------------------------------------------------------------------
`include "gnss_binary_frame_parser_top_macros.svh"

module gnss_binary_frame_parser_top
    import gfp_pkg::*;
#(
    parameter int CAPTURE_BYTES = 20
) (
    input  logic               clk,
    input  logic               rst_n,

    // Byte input
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,

    // Decoded frame output
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        message_type,
    output logic [2:0]         kind,
    output logic [31:0]        time_of_week,
    output logic [31:0]        accuracy,
    output logic signed [31:0] nanosecond,
    output logic [15:0]        year,
    output logic [7:0]         month,
    output logic [7:0]         day,
    output logic [23:0]        clock_hms,
    output logic [3:0]         valid_flags,
    output logic [7:0]         fix_type,
    output logic               checksum_ok,

    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CAP_IDX_W = $clog2(CAPTURE_BYTES);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    phase_t      phase_reg, phase_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] payload_index_reg, payload_index_next;
    logic [15:0] frame_type_reg, frame_type_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  check_a_reg, check_a_next;
    logic [15:0] max_len_reg;
    logic [7:0]  capture_reg [CAPTURE_BYTES];

    // Result register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] res_type_reg;
    kind_t       res_kind_reg;
    logic [31:0] res_tow_reg;
    logic [31:0] res_acc_reg;
    logic [31:0] res_nano_reg;
    logic [15:0] res_year_reg;
    logic [7:0]  res_month_reg;
    logic [7:0]  res_day_reg;
    logic [23:0] res_hms_reg;
    logic [3:0]  res_flags_reg;
    logic [7:0]  res_fix_reg;
    logic        res_ok_reg;

    logic        in_accept;
    logic        result_load;
    logic        cfg_write;
    logic [15:0] payload_index_inc;
    logic [15:0] length_full;
    logic [7:0]  sum_a_add;
    logic        cap_write;
    kind_t       kind_dec;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    // Stall only a second check byte while the held result is not taken
    assign in_ready    = !out_valid_reg || out_ready || (phase_reg != PH_CHECK_B);
    assign in_accept   = in_valid && in_ready;
    assign result_load = in_accept && (phase_reg == PH_CHECK_B);

    assign out_valid_next = result_load ? 1'b1 :
                            (out_ready ? 1'b0 : out_valid_reg);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == 1'(REG_MAX_PAYLOAD_LENGTH));
    assign prdata    = (paddr[2] == 1'(REG_MAX_PAYLOAD_LENGTH)) ?
                       {16'd0, max_len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_PAYLOAD_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            max_len_reg <= pwdata[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Phase sequencing
    // ------------------------------------------------------------------
    assign payload_index_inc = payload_index_reg + 16'd1;
    assign length_full       = {rx_byte, frame_length_reg[7:0]};

    always_comb
    begin
        phase_next = phase_reg;
        if (in_accept)
        begin
            unique case (phase_reg)
                PH_SYNC1:   phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
                PH_SYNC2:   phase_next = (rx_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
                PH_CLASS:   phase_next = PH_ID;
                PH_ID:      phase_next = PH_LEN_LO;
                PH_LEN_LO:  phase_next = PH_LEN_HI;
                PH_LEN_HI:
                begin
                    // Zero length skips the payload; oversize drops the frame
                    if (length_full == 16'd0)
                        phase_next = PH_CHECK_A;
                    else if (length_full > max_len_reg)
                        phase_next = PH_SYNC1;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD: phase_next = (payload_index_inc == frame_length_reg) ?
                                         PH_CHECK_A : PH_PAYLOAD;
                PH_CHECK_A: phase_next = PH_CHECK_B;
                PH_CHECK_B: phase_next = PH_SYNC1;
                default:    phase_next = PH_SYNC1;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Header, index and checksum updates
    // ------------------------------------------------------------------
    assign sum_a_add = sum_a_reg + rx_byte;

    always_comb
    begin
        frame_length_next  = frame_length_reg;
        payload_index_next = payload_index_reg;
        frame_type_next    = frame_type_reg;
        sum_a_next         = sum_a_reg;
        sum_b_next         = sum_b_reg;
        check_a_next       = check_a_reg;
        if (in_accept)
        begin
            unique case (phase_reg)
                PH_SYNC1, PH_SYNC2: ;
                PH_CLASS:
                begin
                    // Restart the sums at the class byte
                    sum_a_next      = rx_byte;
                    sum_b_next      = rx_byte;
                    frame_type_next = {rx_byte, 8'd0};
                end
                PH_ID:
                begin
                    sum_a_next      = sum_a_add;
                    sum_b_next      = sum_b_reg + sum_a_add;
                    frame_type_next = {frame_type_reg[15:8], rx_byte};
                end
                PH_LEN_LO:
                begin
                    sum_a_next        = sum_a_add;
                    sum_b_next        = sum_b_reg + sum_a_add;
                    frame_length_next = {8'd0, rx_byte};
                end
                PH_LEN_HI:
                begin
                    sum_a_next         = sum_a_add;
                    sum_b_next         = sum_b_reg + sum_a_add;
                    frame_length_next  = length_full;
                    payload_index_next = 16'd0;
                end
                PH_PAYLOAD:
                begin
                    sum_a_next         = sum_a_add;
                    sum_b_next         = sum_b_reg + sum_a_add;
                    payload_index_next = (payload_index_inc == frame_length_reg) ?
                                         16'd0 : payload_index_inc;
                end
                PH_CHECK_A: check_a_next = rx_byte;
                PH_CHECK_B: payload_index_next = 16'd0;
                default:    payload_index_next = 16'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SYNC1;
            frame_length_reg  <= 16'd0;
            payload_index_reg <= 16'd0;
            frame_type_reg    <= 16'd0;
            sum_a_reg         <= 8'd0;
            sum_b_reg         <= 8'd0;
            check_a_reg       <= 8'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            frame_length_reg  <= frame_length_next;
            payload_index_reg <= payload_index_next;
            frame_type_reg    <= frame_type_next;
            sum_a_reg         <= sum_a_next;
            sum_b_reg         <= sum_b_next;
            check_a_reg       <= check_a_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload capture: clear on first sync byte, store leading bytes
    // ------------------------------------------------------------------
    assign cap_write = in_accept && (phase_reg == PH_PAYLOAD) &&
                       (payload_index_reg < 16'(CAPTURE_BYTES));

    always_ff @(posedge clk)
    begin
        if (in_accept && (phase_reg == PH_SYNC1) && (rx_byte == SYNC_FIRST))
        begin
            for (int i = 0; i < CAPTURE_BYTES; i++)
                capture_reg[i] <= 8'd0;
        end
        else if (cap_write)
        begin
            capture_reg[payload_index_reg[CAP_IDX_W-1:0]] <= rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Result decode, loaded on the second check byte
    // ------------------------------------------------------------------
    assign kind_dec = decode_kind(frame_type_reg);

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            res_type_reg  <= frame_type_reg;
            res_kind_reg  <= kind_dec;
            res_ok_reg    <= (check_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);
            res_tow_reg   <= 32'd0;
            res_acc_reg   <= 32'd0;
            res_nano_reg  <= 32'd0;
            res_year_reg  <= 16'd0;
            res_month_reg <= 8'd0;
            res_day_reg   <= 8'd0;
            res_hms_reg   <= 24'd0;
            res_flags_reg <= 4'd0;
            res_fix_reg   <= 8'd0;
            if (kind_dec == KIND_NAV_ST)
            begin
                res_tow_reg   <= {capture_reg[3], capture_reg[2],
                                  capture_reg[1], capture_reg[0]};
                res_fix_reg   <= capture_reg[4];
                res_flags_reg <= capture_reg[5][3:0];
            end
            else if (kind_dec == KIND_UTC)
            begin
                res_tow_reg   <= {capture_reg[3], capture_reg[2],
                                  capture_reg[1], capture_reg[0]};
                res_acc_reg   <= {capture_reg[7], capture_reg[6],
                                  capture_reg[5], capture_reg[4]};
                res_nano_reg  <= {capture_reg[11], capture_reg[10],
                                  capture_reg[9], capture_reg[8]};
                res_year_reg  <= {capture_reg[13], capture_reg[12]};
                res_month_reg <= capture_reg[14];
                res_day_reg   <= capture_reg[15];
                res_hms_reg   <= {capture_reg[16], capture_reg[17], capture_reg[18]};
                res_flags_reg <= {1'b0, capture_reg[19][2:0]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign out_valid    = out_valid_reg;
    assign message_type = res_type_reg;
    assign kind         = res_kind_reg;
    assign time_of_week = res_tow_reg;
    assign accuracy     = res_acc_reg;
    assign nanosecond   = res_nano_reg;
    assign year         = res_year_reg;
    assign month        = res_month_reg;
    assign day          = res_day_reg;
    assign clock_hms    = res_hms_reg;
    assign valid_flags  = res_flags_reg;
    assign fix_type     = res_fix_reg;
    assign checksum_ok  = res_ok_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GFP_ASSERT_NOW(a_hold_check_b, clk, rst_n, out_valid_reg && !out_ready && (phase_reg == PH_CHECK_B), !in_ready, "second check byte taken over a held result")
    `GFP_ASSERT_NEXT(a_result_follows, clk, rst_n, result_load, out_valid_reg && (phase_reg == PH_SYNC1), "no result after second check byte")
    `GFP_ASSERT_NOW(a_index_in_range, clk, rst_n, phase_reg == PH_PAYLOAD, payload_index_reg < frame_length_reg, "payload index past frame length")
    `GFP_ASSERT_NEXT(a_payload_end, clk, rst_n, in_accept && (phase_reg == PH_PAYLOAD) && (payload_index_inc == frame_length_reg), (phase_reg == PH_CHECK_A) && (payload_index_reg == 16'd0), "payload end missed")

endmodule
